FILE: sv/assert_macros.svh
// Assertion macros shared by the scan sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: sv/ladc_pkg.sv
// Shared types, constants and command structs of the LED ADC scan sequencer.
`default_nettype none

package ladc_pkg;

  // Default geometry of the LED array
  localparam int unsigned NumLeds      = 6;
  localparam int unsigned ColorsPerLed = 3;

  // Field widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned SampleW = 10;
  localparam int unsigned LedNumW = 3;
  localparam int unsigned ColorW  = 2;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned MvW     = 14;
  // Wide enough for any slot, channel or store index before range checks
  localparam int unsigned WideW   = 6;

  // Millivolt scaling: mv = sample * 4 * 5000 / 2046
  localparam int unsigned AdcFullMv   = 5000;
  localparam int unsigned SampleScale = 4;
  localparam int unsigned AdcDivisor  = 2046;
  localparam int unsigned MvScale     = SampleScale * AdcFullMv;
  // Done as sample * MvRecip >> MvShift with the reciprocal rounded up; the
  // reduced divisor is 1023 and 2^MvShift exceeds its square, so the
  // truncated quotient is exact for every sample value.
  localparam int unsigned MvShift = 20;
  localparam longint unsigned MvRecip =
    ((longint'(MvScale) << MvShift) + longint'(AdcDivisor) - 1) / longint'(AdcDivisor);
  localparam int unsigned RecipW  = $clog2(MvRecip + 1);
  localparam int unsigned ProdW   = SampleW + RecipW;

  typedef enum logic [ModeW-1:0] {
    MODE_CONV   = 3'd0,
    MODE_SET_EN = 3'd1,
    MODE_SWAP   = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  // Controller to datapath
  typedef struct packed {
    logic apply;  // accepted beat: update state, capture readback
    logic scale;  // scale the latched sample to millivolts
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scale;  // current beat is a voltage read of a valid channel
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/led_adc_scan_sequencer.sv
// Top level of the LED ADC scan sequencer.
`default_nettype none

// Scans the LED forward-voltage ADC slots, then supply, then temperature,
// one command beat in and one result beat out per beat. Conversion, enable,
// swap, clear and all other beats write their result on accept; a voltage
// read of a valid channel adds a scaling step (the stored sample is latched
// in the accept cycle, then scaled to millivolts by a reciprocal multiplication
// in the next). The result sits in an output register, and the next beat is
// taken in the cycle that result is taken. Enable bits and the sample store clear at reset.
module led_adc_scan_sequencer #(
  parameter int unsigned NUM_LEDS       = ladc_pkg::NumLeds,
  parameter int unsigned COLORS_PER_LED = ladc_pkg::ColorsPerLed
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ladc_pkg::ModeW-1:0]    mode_i,
  input  logic [ladc_pkg::SampleW-1:0]  sample_i,
  input  logic [ladc_pkg::LedNumW-1:0]  led_number_i,
  input  logic [ladc_pkg::ColorW-1:0]   color_i,
  input  logic                          enable_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ladc_pkg::SlotW-1:0]    program_slot_o,
  output logic                          data_ready_o,
  output logic [ladc_pkg::SampleW-1:0]  supply_sample_o,
  output logic [ladc_pkg::SampleW-1:0]  temperature_sample_o,
  output logic [ladc_pkg::MvW-1:0]      voltage_mv_o,
  output logic                          enable_readback_o
);
  import ladc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ladc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ladc_dpath #(
    .NUM_LEDS       (NUM_LEDS),
    .COLORS_PER_LED (COLORS_PER_LED)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .mode_i               (mode_i),
    .sample_i             (sample_i),
    .led_number_i         (led_number_i),
    .color_i              (color_i),
    .enable_value_i       (enable_value_i),
    .program_slot_o       (program_slot_o),
    .data_ready_o         (data_ready_o),
    .supply_sample_o      (supply_sample_o),
    .temperature_sample_o (temperature_sample_o),
    .voltage_mv_o         (voltage_mv_o),
    .enable_readback_o    (enable_readback_o)
  );

endmodule

`default_nettype wire

FILE: sv/ladc_dpath.sv
// Datapath: scan state, enable banks, sample store and millivolt scaling.
`default_nettype none

module ladc_dpath #(
  parameter int unsigned NUM_LEDS       = ladc_pkg::NumLeds,
  parameter int unsigned COLORS_PER_LED = ladc_pkg::ColorsPerLed
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ladc_pkg::cmd_t                cmd_i,
  output ladc_pkg::stat_t               stat_o,
  input  logic [ladc_pkg::ModeW-1:0]    mode_i,
  input  logic [ladc_pkg::SampleW-1:0]  sample_i,
  input  logic [ladc_pkg::LedNumW-1:0]  led_number_i,
  input  logic [ladc_pkg::ColorW-1:0]   color_i,
  input  logic                          enable_value_i,
  output logic [ladc_pkg::SlotW-1:0]    program_slot_o,
  output logic                          data_ready_o,
  output logic [ladc_pkg::SampleW-1:0]  supply_sample_o,
  output logic [ladc_pkg::SampleW-1:0]  temperature_sample_o,
  output logic [ladc_pkg::MvW-1:0]      voltage_mv_o,
  output logic                          enable_readback_o
);
  import ladc_pkg::*;

  localparam int unsigned LedSlots = NUM_LEDS * COLORS_PER_LED;
  localparam int unsigned IdxW     = (LedSlots > 1) ? $clog2(LedSlots) : 1;
  localparam int unsigned OddBase  = (LedSlots + 1) / 2;
  localparam logic [SlotW-1:0] TempSlot5 = SlotW'(LedSlots + 1);

  // Store index of an LED slot: even slots first, odd slots after
  function automatic logic [WideW-1:0] store_index(input logic [SlotW-1:0] k);
    logic [WideW-1:0] half;
    half = WideW'(k >> 1);
    if (k[0]) begin
      return WideW'(OddBase) + half;
    end
    return half;
  endfunction

  function automatic logic bank_bit(input logic [LedSlots-1:0] bits,
                                    input logic [WideW-1:0]    idx);
    if (idx >= WideW'(LedSlots)) begin
      return 1'b0;
    end
    return bits[idx[IdxW-1:0]];
  endfunction

  // State
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [SlotW-1:0]    prog_q, prog_d;
  logic                active_q, active_d;
  logic                swap_q, swap_d;
  logic                ready_q, ready_d;
  logic [SampleW-1:0]  supply_q, supply_d;
  logic [SampleW-1:0]  temp_q, temp_d;
  logic [LedSlots-1:0] bank_q [2];
  logic [LedSlots-1:0] bank_d [2];
  logic [SampleW-1:0]  store_q [LedSlots];

  // Result and scaling
  logic                rb_q, rb_d;
  logic [MvW-1:0]      mv_q;
  logic [SampleW-1:0]  rd_q;
  logic [ProdW-1:0]    prod;
  logic [SampleW-1:0]  rd_sample;

  // Decode helpers
  logic                chan_ok;
  logic [WideW-1:0]    chan_w;
  logic [IdxW-1:0]     chan_idx;
  logic [WideW-1:0]    kx;
  logic [WideW-1:0]    sidx;
  logic                st_we;
  logic [IdxW-1:0]     st_idx;
  logic                next_ok;

  // Channel select from LED number and colour
  assign chan_ok  = ({1'b0, led_number_i} < (LedNumW + 1)'(NUM_LEDS)) &&
                    ({1'b0, color_i} < (ColorW + 1)'(COLORS_PER_LED));
  assign chan_w   = WideW'(led_number_i) * WideW'(COLORS_PER_LED) + WideW'(color_i);
  assign chan_idx = chan_w[IdxW-1:0];

  assign kx   = WideW'(slot_q);
  assign sidx = store_index(slot_q);

  // Next-state logic for one beat
  always_comb begin
    slot_d   = slot_q;
    prog_d   = prog_q;
    active_d = active_q;
    swap_d   = swap_q;
    ready_d  = ready_q;
    supply_d = supply_q;
    temp_d   = temp_q;
    bank_d   = bank_q;
    st_we    = 1'b0;
    st_idx   = sidx[IdxW-1:0];
    next_ok  = 1'b1;
    case (mode_i)
      MODE_CONV: begin
        if (kx < WideW'(LedSlots)) begin
          st_we  = bank_bit(bank_q[active_q], sidx);
          slot_d = slot_q + SlotW'(1);
        end else if (kx == WideW'(LedSlots)) begin
          supply_d = sample_i;
          slot_d   = slot_q + SlotW'(1);
        end else begin
          temp_d  = sample_i;
          slot_d  = '0;
          ready_d = 1'b1;
        end
        // disabled LED slots are replaced by the temperature slot
        if (WideW'(slot_d) < WideW'(LedSlots)) begin
          next_ok = bank_bit(bank_q[active_q], store_index(slot_d));
        end
        prog_d = next_ok ? slot_d : TempSlot5;
        if (swap_q) begin
          swap_d   = 1'b0;
          active_d = ~active_q;
        end
      end
      MODE_SET_EN: begin
        if (chan_ok) begin
          bank_d[~active_q][chan_idx] = enable_value_i;
        end
      end
      MODE_SWAP:  swap_d  = 1'b1;
      MODE_CLEAR: ready_d = 1'b0;
      default: ;
    endcase
    rb_d = chan_ok && bank_d[~active_d][chan_idx];
  end

  // Voltage read: latch the stored sample, then scale by the reciprocal
  assign stat_o.need_scale = (mode_i == MODE_READ) && chan_ok;
  assign rd_sample = store_q[chan_idx];
  assign prod      = ProdW'(rd_q) * ProdW'(MvRecip);

  // Control and status state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      prog_q    <= TempSlot5;
      active_q  <= 1'b0;
      swap_q    <= 1'b0;
      ready_q   <= 1'b0;
      supply_q  <= '0;
      temp_q    <= '0;
      bank_q[0] <= '0;
      bank_q[1] <= '0;
      for (int i = 0; i < LedSlots; i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.apply) begin
      slot_q   <= slot_d;
      prog_q   <= prog_d;
      active_q <= active_d;
      swap_q   <= swap_d;
      ready_q  <= ready_d;
      supply_q <= supply_d;
      temp_q   <= temp_d;
      bank_q   <= bank_d;
      if (st_we) begin
        store_q[st_idx] <= sample_i;
      end
    end
  end

  // Result registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      rb_q <= rb_d;
      rd_q <= rd_sample;
    end
    if (cmd_i.scale) begin
      mv_q <= prod[MvShift +: MvW];
    end else if (cmd_i.apply && !stat_o.need_scale) begin
      mv_q <= '0;
    end
  end

  assign program_slot_o       = prog_q;
  assign data_ready_o         = ready_q;
  assign supply_sample_o      = supply_q;
  assign temperature_sample_o = temp_q;
  assign voltage_mv_o         = mv_q;
  assign enable_readback_o    = rb_q;

`include "assert_macros.svh"
  `ASSERT_AT(a_prog_slot, (prog_q == slot_q) || (prog_q == TempSlot5))
  `ASSERT_AT(a_slot_range, slot_q <= TempSlot5)
  `ASSERT_NEVER(a_scale_excl, cmd_i.apply && cmd_i.scale)

endmodule

`default_nettype wire

FILE: sv/ladc_ctrl.sv
// Controller: beat handshake, output valid and millivolt scaling step.
`default_nettype none

module ladc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ladc_pkg::stat_t stat_i,
  output ladc_pkg::cmd_t  cmd_o
);
  import ladc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SCALE = 2'b10
  } state_e;

  state_e st_q, st_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // New beat only when the output register is free or being emptied
  assign in_ready_o = (st_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.apply = 1'b1;
          if (stat_i.need_scale) begin
            st_d = ST_SCALE;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        st_d        = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`include "assert_macros.svh"
  `ASSERT_AT(a_scale_out_free, (st_q == ST_SCALE) |-> !out_valid_q)
  `ASSERT_AT(a_scale_entry, (accept && stat_i.need_scale) |=> (st_q == ST_SCALE))
  `ASSERT_AT(a_scale_exit, cmd_o.scale |=> ((st_q == ST_IDLE) && out_valid_q))

endmodule

`default_nettype wire

FILE: sim/led_adc_scan_sequencer_tb.sv
// Self-checking testbench for the LED ADC scan sequencer: directed and random beats.
`default_nettype none

module led_adc_scan_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ladc_pkg::*;

  localparam int unsigned LedSlots    = NumLeds * ColorsPerLed;
  localparam int unsigned SupplySlot  = LedSlots;
  localparam int unsigned TempSlot    = LedSlots + 1;
  localparam int unsigned OddBase     = (LedSlots + 1) / 2;
  localparam int unsigned SpareModeLo = 5;
  localparam int unsigned SpareModeHi = (1 << ModeW) - 1;
  localparam int unsigned MaxWait     = 15;
  localparam int unsigned RandomBeats = 600;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned ReportMax   = 10;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [SampleW-1:0] sample;
    logic [LedNumW-1:0] led;
    logic [ColorW-1:0]  color;
    logic               en;
    logic               drain;  // hold off until every result is back
  } seq_cmd_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic               ready;
    logic [SampleW-1:0] supply;
    logic [SampleW-1:0] temp;
    logic [MvW-1:0]     mv;
    logic               rb;
  } scan_beat_t;

  // Clock, reset and pins
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  logic [ModeW-1:0]   cmd_mode = '0;
  logic [SampleW-1:0] cmd_sample = '0;
  logic [LedNumW-1:0] cmd_led = '0;
  logic [ColorW-1:0]  cmd_color = '0;
  logic               cmd_en = 1'b0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [SlotW-1:0]   res_slot;
  logic               res_data_ready;
  logic [SampleW-1:0] res_supply;
  logic [SampleW-1:0] res_temp;
  logic [MvW-1:0]     res_mv;
  logic               res_rb;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  led_adc_scan_sequencer dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (cmd_valid),
    .in_ready_o          (cmd_ready),
    .mode_i              (cmd_mode),
    .sample_i            (cmd_sample),
    .led_number_i        (cmd_led),
    .color_i             (cmd_color),
    .enable_value_i      (cmd_en),
    .out_valid_o         (res_valid),
    .out_ready_i         (res_ready),
    .program_slot_o      (res_slot),
    .data_ready_o        (res_data_ready),
    .supply_sample_o     (res_supply),
    .temperature_sample_o(res_temp),
    .voltage_mv_o        (res_mv),
    .enable_readback_o   (res_rb)
  );

  // Shadow copy of the sequencer state
  logic [4:0]          slot_q     = '0;
  logic                bank_sel   = 1'b0;
  logic                swap_req   = 1'b0;
  logic [LedSlots-1:0] en_bank [2] = '{default: '0};
  logic [SampleW-1:0]  sample_store [LedSlots] = '{default: '0};
  logic [SampleW-1:0]  supply_val = '0;
  logic [SampleW-1:0]  temp_val   = '0;
  logic                scan_done  = 1'b0;
  logic [SlotW-1:0]    next_slot  = SlotW'(TempSlot);

  // Run bookkeeping
  seq_cmd_t   pending_cmds [$];
  scan_beat_t expected_beats [$];
  seq_cmd_t   cur_cmd;
  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned feed_wait    = 0;
  int unsigned sink_wait    = 0;
  bit          feed_calm    = 1'b0;
  bit          sink_calm    = 1'b0;
  int unsigned n_conv = 0, n_wrap = 0, n_stored = 0, n_reads = 0, n_swaps = 0;

  function automatic int unsigned store_idx(input int unsigned k);
    return (k % 2 == 1) ? OddBase + k / 2 : k / 2;
  endfunction

  // LED slots are measured only when enabled in the active bank
  function automatic bit slot_live(input int unsigned k);
    if (k >= LedSlots) return 1'b1;
    return en_bank[bank_sel][store_idx(k)];
  endfunction

  // Apply one command to the shadow state and form its result beat
  function automatic scan_beat_t predict_beat(input seq_cmd_t c);
    scan_beat_t  r;
    bit          chan_ok;
    int unsigned chan;
    int unsigned k;
    int unsigned idx;
    chan_ok = (c.led < NumLeds) && (c.color < ColorsPerLed);
    chan    = c.led * ColorsPerLed + c.color;
    r       = '0;
    case (c.mode)
      MODE_CONV: begin
        n_conv++;
        k = slot_q;
        if (k < LedSlots) begin
          idx = store_idx(k);
          if (en_bank[bank_sel][idx]) begin
            sample_store[idx] = c.sample;
            n_stored++;
          end
          slot_q = SlotW'(k + 1);
        end else if (k == SupplySlot) begin
          supply_val = c.sample;
          slot_q     = SlotW'(k + 1);
        end else begin
          temp_val  = c.sample;
          slot_q    = '0;
          scan_done = 1'b1;
          n_wrap++;
        end
        next_slot = slot_live(slot_q) ? SlotW'(slot_q) : SlotW'(TempSlot);
        if (swap_req) begin
          swap_req = 1'b0;
          bank_sel = ~bank_sel;
          n_swaps++;
        end
      end
      MODE_SET_EN: begin
        if (chan_ok) en_bank[~bank_sel][chan] = c.en;
      end
      MODE_SWAP:  swap_req  = 1'b1;
      MODE_CLEAR: scan_done = 1'b0;
      MODE_READ: begin
        if (chan_ok) begin
          r.mv = MvW'((int'(sample_store[chan]) * MvScale) / AdcDivisor);
          n_reads++;
        end
      end
      default: ;
    endcase
    if (chan_ok) r.rb = en_bank[~bank_sel][chan];
    r.slot   = next_slot;
    r.ready  = scan_done;
    r.supply = supply_val;
    r.temp   = temp_val;
    return r;
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MaxWait);
  endfunction

  function automatic logic [LedNumW-1:0] rand_led();
    if ($urandom_range(0, 7) == 0) return LedNumW'($urandom_range(0, (1 << LedNumW) - 1));
    return LedNumW'($urandom_range(0, NumLeds - 1));
  endfunction

  function automatic logic [ColorW-1:0] rand_color();
    if ($urandom_range(0, 7) == 0) return ColorW'($urandom_range(0, (1 << ColorW) - 1));
    return ColorW'($urandom_range(0, ColorsPerLed - 1));
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SampleW'($urandom_range(0, (1 << SampleW) - 1));
    endcase
  endfunction

  task automatic add_cmd(input logic [ModeW-1:0] mode, input logic [SampleW-1:0] sample,
                         input logic [LedNumW-1:0] led, input logic [ColorW-1:0] color,
                         input logic en, input logic drain = 1'b0);
    seq_cmd_t c;
    c.mode   = mode;
    c.sample = sample;
    c.led    = led;
    c.color  = color;
    c.en     = en;
    c.drain  = drain;
    pending_cmds.push_back(c);
  endtask

  // Driver: presents queued commands, predicts on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin : feed
    int unsigned sent_now;
    if (!rst_ni) begin
      cmd_valid  <= 1'b0;
      beats_sent <= 0;
    end else begin
      sent_now = beats_sent;
      if (cmd_valid && cmd_ready) begin
        expected_beats.push_back(predict_beat(cur_cmd));
        sent_now++;
        beats_sent <= sent_now;
        feed_wait = draw_wait(feed_calm);
        if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
      end
      if (!cmd_valid || cmd_ready) begin
        if (feed_wait != 0) begin
          feed_wait--;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].drain || results_seen == sent_now)) begin
          cur_cmd    = pending_cmds.pop_front();
          cmd_valid  <= 1'b1;
          cmd_mode   <= cur_cmd.mode;
          cmd_sample <= cur_cmd.sample;
          cmd_led    <= cur_cmd.led;
          cmd_color  <= cur_cmd.color;
          cmd_en     <= cur_cmd.en;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result beats with random back-pressure, checks each one
  always @(posedge clk_i or negedge rst_ni) begin : sink
    scan_beat_t got;
    scan_beat_t want;
    if (!rst_ni) begin
      res_ready    <= 1'b0;
      results_seen <= 0;
    end else begin
      if (res_valid && res_ready) begin
        got = '{res_slot, res_data_ready, res_supply, res_temp, res_mv, res_rb};
        results_seen <= results_seen + 1;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("[%0t] result beat with nothing expected: slot=%0d mv=%0d", $realtime,
                     got.slot, got.mv);
        end else begin
          want = expected_beats.pop_front();
          if (got.slot !== want.slot || got.ready !== want.ready ||
              got.supply !== want.supply || got.temp !== want.temp ||
              got.mv !== want.mv || got.rb !== want.rb) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display({"[%0t] mismatch: exp slot=%0d rdy=%0b sup=%0d tmp=%0d mv=%0d rb=%0b",
                        " / got slot=%0d rdy=%0b sup=%0d tmp=%0d mv=%0d rb=%0b"}, $realtime,
                       want.slot, want.ready, want.supply, want.temp, want.mv, want.rb,
                       got.slot, got.ready, got.supply, got.temp, got.mv, got.rb);
          end
        end
        sink_wait = draw_wait(sink_calm);
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      end
      if (sink_wait != 0) begin
        sink_wait--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d results back", cycles, results_seen,
               beats_sent);
      $display("led_adc_scan_sequencer_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n_rand;
    int unsigned n;
    int unsigned i;
    bit          noise;

    // Directed: empty store read, spare mode with all bits set, enable writes
    // including out-of-range channels, swap, stores through the new bank
    add_cmd(MODE_READ, '0, 0, 0, 1'b0);
    add_cmd(ModeW'(SpareModeHi), '1, '1, '1, 1'b1);
    add_cmd(MODE_SET_EN, '0, 0, 0, 1'b1);
    add_cmd(MODE_SET_EN, '0, 3, 0, 1'b1);
    add_cmd(MODE_SET_EN, '0, LedNumW'(NumLeds - 1), ColorW'(ColorsPerLed - 1), 1'b1);
    add_cmd(MODE_SET_EN, '0, '1, '1, 1'b1);
    add_cmd(MODE_SET_EN, '0, LedNumW'(NumLeds), 1, 1'b1);
    add_cmd(MODE_SET_EN, '0, 2, '1, 1'b1);
    add_cmd(MODE_SWAP, '0, 0, 0, 1'b0, 1'b1);
    add_cmd(MODE_CONV, '1, 0, 0, 1'b0);    // not stored, bank flips after
    add_cmd(MODE_CONV, '1, 0, 0, 1'b0);    // odd slot lands in upper half
    add_cmd(MODE_READ, '0, 3, 0, 1'b0);    // full-scale millivolts
    add_cmd(MODE_SET_EN, '0, 3, 0, 1'b0);
    add_cmd(MODE_SET_EN, '0, 1, 1, 1'b1);
    add_cmd(MODE_CONV, '0, 0, 0, 1'b0);
    add_cmd(MODE_CONV, 10'h2AA, 0, 0, 1'b0);
    add_cmd(MODE_CONV, 10'h155, 0, 0, 1'b0);
    add_cmd(MODE_CLEAR, '0, 0, 0, 1'b0);
    add_cmd(ModeW'(SpareModeLo), '0, 0, 0, 1'b0);
    add_cmd(MODE_READ, '0, LedNumW'(NumLeds - 1), ColorW'(ColorsPerLed - 1), 1'b0);
    add_cmd(MODE_READ, '0, '1, '1, 1'b0);
    add_cmd(MODE_READ, '0, 0, '1, 1'b0);
    add_cmd(MODE_SWAP, '0, 0, 0, 1'b0);
    add_cmd(MODE_CONV, '1, 0, 0, 1'b0);

    // Random: scan bursts, bank programming usually followed by a swap, reads, clears, swaps and noise
    n_rand = 0;
    while (n_rand < RandomBeats) begin
      noise = 1'b0;
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++)
            add_cmd(MODE_SET_EN, rand_sample(), rand_led(), rand_color(),
                    $urandom_range(0, 3) != 0);
          if ($urandom_range(0, 4) != 0) begin
            add_cmd(MODE_SWAP, rand_sample(), rand_led(), rand_color(),
                    1'($urandom_range(0, 1)));
            n++;
          end
        end
        2, 3, 4, 5: begin
          n = $urandom_range(1, 22);
          for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
              add_cmd(MODE_READ, rand_sample(), rand_led(), rand_color(),
                      1'($urandom_range(0, 1)));
            else
              add_cmd(MODE_CONV, rand_sample(), rand_led(), rand_color(),
                      1'($urandom_range(0, 1)));
          end
        end
        6, 7: begin
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++)
            add_cmd(MODE_READ, rand_sample(), rand_led(), rand_color(),
                    1'($urandom_range(0, 1)));
        end
        8: begin
          n = 1;
          add_cmd($urandom_range(0, 1) ? MODE_CLEAR : MODE_SWAP, rand_sample(), rand_led(),
                  rand_color(), 1'($urandom_range(0, 1)));
        end
        default: begin
          noise = 1'b1;
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++)
            add_cmd(ModeW'($urandom_range(0, SpareModeHi)),
                    SampleW'($urandom_range(0, (1 << SampleW) - 1)),
                    LedNumW'($urandom_range(0, (1 << LedNumW) - 1)),
                    ColorW'($urandom_range(0, (1 << ColorW) - 1)),
                    1'($urandom_range(0, 1)));
        end
      endcase
      // now and then make the group's last beat wait for the pipeline to empty
      if ($urandom_range(0, 15) == 0) pending_cmds[pending_cmds.size() - 1].drain = 1'b1;
      if (!noise) n_rand += n;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || cmd_valid || results_seen != beats_sent)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (expected_beats.size() != 0) begin
      mismatches++;
      $display("%0d expected result beats never arrived", expected_beats.size());
    end

    $display("covered %0d beats: %0d conversions (%0d stored, %0d full scans), %0d swaps",
             beats_sent, n_conv, n_stored, n_wrap, n_swaps);
    $display("%0d millivolt reads of valid channels, %0d mismatches in %0d cycles",
             n_reads, mismatches, cycles);
    if (mismatches == 0) begin
      $display("led_adc_scan_sequencer_tb: PASS");
    end else begin
      $display("led_adc_scan_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
